// ===== hdl/fir_filter_loadable_taps_defines.svh =====
// Assertion macros for the filter top level.
`ifndef FIR_FILTER_LOADABLE_TAPS_DEFINES_SVH
`define FIR_FILTER_LOADABLE_TAPS_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define FLT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define FLT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== hdl/fir_lt_pkg.sv =====
package fir_lt_pkg;

  localparam int TAP_COUNT   = 101;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 16;
  localparam int INDEX_BITS  = 7;

  localparam int TAP_W  = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int FILL_W = $clog2(TAP_COUNT + 1);
  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W  = PROD_W + FILL_W;

  localparam int S_DATA_BITS = SAMPLE_BITS + INDEX_BITS + COEF_BITS;
  localparam int S_TDATA_W   = ((S_DATA_BITS + 7) / 8) * 8;
  localparam int M_TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_ROUND,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_coef;
    logic push_sample;
    logic issue;
    logic round;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic last_tap;
    logic pipe_busy;
    logic out_full;
  } dp_sts_t;

endpackage

// ===== hdl/fir_lt_ctrl.sv =====
module fir_lt_ctrl import fir_lt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_cmd,
  output logic    in_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == CMD_LOAD) begin
            cmd.load_coef = 1'b1;
          end else begin
            cmd.push_sample = 1'b1;
            state_next      = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        if (sts.last_tap) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round  = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts.out_full) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/fir_lt_datapath.sv =====
module fir_lt_datapath import fir_lt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  dp_cmd_t                 cmd,
  output dp_sts_t                 sts,
  input  logic [SAMPLE_BITS-1:0]  sample_in,
  input  logic [INDEX_BITS-1:0]   tap_index,
  input  logic [COEF_BITS-1:0]    tap_value,
  output logic [SAMPLE_BITS-1:0]  sample_out,
  output logic                    clipped,
  output logic                    out_valid,
  input  logic                    out_ready
);

  localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(TAP_COUNT - 1);
  localparam logic [ACC_W-1:0] HALF     = ACC_W'(1) << (COEF_BITS - 2);
  localparam int               HI_W     = ACC_W - SAMPLE_BITS + 1;

  logic signed [SAMPLE_BITS-1:0] delay_mem [TAP_COUNT];
  logic signed [COEF_BITS-1:0]   coef_mem  [TAP_COUNT];

  logic [TAP_W-1:0]  head, head_next, tap, rp;
  logic [FILL_W-1:0] fill;
  logic              coef_we;

  logic signed [SAMPLE_BITS-1:0] rd_sample;
  logic signed [COEF_BITS-1:0]   rd_coef;
  logic                          rd_vld, rd_ok;
  logic signed [PROD_W-1:0]      mult, prod;
  logic                          prod_vld;
  logic signed [ACC_W-1:0]       acc, rnd, shifted;
  logic [HI_W-1:0]               hi_bits;
  logic                          fits;
  logic [SAMPLE_BITS-1:0]        sat_value;

  assign head_next = (head == LAST_TAP) ? '0 : head + 1'b1;
  assign coef_we   = cmd.load_coef && (32'(tap_index) < 32'(TAP_COUNT));

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[TAP_W'(tap_index)] <= tap_value;
    end
    if (cmd.push_sample) begin
      delay_mem[head_next] <= sample_in;
    end
    if (cmd.issue) begin
      rd_sample <= delay_mem[rp];
      rd_coef   <= coef_mem[tap];
      rd_ok     <= FILL_W'(tap) < fill;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      fill     <= '0;
      rd_vld   <= 1'b0;
      prod_vld <= 1'b0;
    end else begin
      rd_vld   <= cmd.issue;
      prod_vld <= rd_vld;
      if (cmd.push_sample) begin
        head <= head_next;
        if (fill != FILL_W'(TAP_COUNT)) begin
          fill <= fill + 1'b1;
        end
      end
    end
  end

  // advance tap and read pointer: newest sample first, walking back in time
  always_ff @(posedge clk) begin
    if (cmd.push_sample) begin
      tap <= '0;
      rp  <= head_next;
    end else if (cmd.issue) begin
      tap <= tap + 1'b1;
      rp  <= (rp == '0) ? LAST_TAP : rp - 1'b1;
    end
  end

  assign mult = rd_sample * rd_coef;

  always_ff @(posedge clk) begin
    prod <= rd_ok ? mult : '0;
    if (cmd.push_sample) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
    end
    if (cmd.round) begin
      rnd <= acc + HALF;
    end
  end

  assign shifted   = rnd >>> (COEF_BITS - 1);
  assign hi_bits   = shifted[ACC_W-1:SAMPLE_BITS-1];
  assign fits      = (&hi_bits) || !(|hi_bits);
  assign sat_value = shifted[ACC_W-1] ? {1'b1, {(SAMPLE_BITS - 1){1'b0}}}
                                      : {1'b0, {(SAMPLE_BITS - 1){1'b1}}};

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      sample_out <= fits ? shifted[SAMPLE_BITS-1:0] : sat_value;
      clipped    <= !fits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.last_tap  = (tap == LAST_TAP);
  assign sts.pipe_busy = rd_vld || prod_vld;
  assign sts.out_full  = out_valid && !out_ready;

endmodule

// ===== hdl/fir_filter_loadable_taps.sv =====
// Load item: taken while idle, gives no output item.
// Sample item: one multiply-accumulate unit walks all TAP_COUNT taps, one tap per
// cycle; the next item is taken once the result sits in the output register, so a
// new sample is never taken while the last one is still being filtered.
// Reset (rst, synchronous, active high) empties the delay line and the output;
// the coefficient store keeps no reset value and must be loaded before use.
`include "fir_filter_loadable_taps_defines.svh"

module fir_filter_loadable_taps import fir_lt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,   // sample_in, tap_index, tap_value, zero pad
  input  logic [0:0]            s_tuser,   // cmd
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,   // sample_out, zero pad
  output logic [0:0]            m_tuser    // clipped
);

  dp_cmd_t                dcmd;
  dp_sts_t                sts;
  logic [SAMPLE_BITS-1:0] sample_out;
  logic                   clipped;

  fir_lt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_cmd   (s_tuser[0]),
    .in_ready (s_tready),
    .cmd      (dcmd),
    .sts      (sts)
  );

  fir_lt_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (dcmd),
    .sts        (sts),
    .sample_in  (s_tdata[SAMPLE_BITS-1:0]),
    .tap_index  (s_tdata[SAMPLE_BITS +: INDEX_BITS]),
    .tap_value  (s_tdata[SAMPLE_BITS + INDEX_BITS +: COEF_BITS]),
    .sample_out (sample_out),
    .clipped    (clipped),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready)
  );

  assign m_tdata    = M_TDATA_W'(sample_out);
  assign m_tuser[0] = clipped;

  `FLT_ASSERT_NXT(a_sample_busy, s_tvalid && s_tready && s_tuser[0] == CMD_SAMPLE, !s_tready)
  `FLT_ASSERT_NXT(a_load_idle, s_tvalid && s_tready && s_tuser[0] == CMD_LOAD, s_tready)
  `FLT_ASSERT_IMP(a_busy_blocks, sts.pipe_busy, !s_tready)
  `FLT_ASSERT_IMP(a_emit_room, dcmd.emit, !(m_tvalid && !m_tready))

endmodule
